// ===== rtl/core/lircm_pkg.sv =====
// Package for the learned IR code matcher.
// Holds default sizes, output field width and the controller/datapath bundles.
// No dependencies.
package lircm_pkg;

   localparam int NUM_SLOTS_DEFAULT = 8;
   localparam int CODE_BITS_DEFAULT = 32;
   localparam int OUT_FIELD_BITS    = 4;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/lircm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lircm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lircm_ctrl.sv =====
// Controller state machine for the learned IR code matcher.
// Depends on lircm_pkg for the command and status bundles.
module lircm_ctrl
   import lircm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = status.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lircm_datapath.sv =====
// Datapath for the learned IR code matcher: code table, scan, state and result register.
// Depends on lircm_pkg and lircm_ram.
module lircm_datapath
   import lircm_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_mode,
   input  logic [CODE_BITS-1:0]      req_code,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [OUT_FIELD_BITS-1:0] rsp_key_index,
   output logic                      rsp_report_needed,
   output logic                      rsp_learned,
   output logic                      rsp_duplicate,
   output logic [OUT_FIELD_BITS-1:0] rsp_learn_slot,
   output logic                      rsp_learn_done,
   input  cmd_type                   cmd,
   output status_type                status
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int POS_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [POS_W-1:0]  MAX_POS   = POS_W'(NUM_SLOTS);

   logic                 mode_ff;
   logic [CODE_BITS-1:0] code_ff;
   logic [CODE_BITS-1:0] prev_ff;
   logic [POS_W-1:0]     key_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [SLOT_W-1:0]    rd_addr_ff;
   logic                 cmp_pend_ff;
   logic [SLOT_W-1:0]    cmp_addr_ff;
   logic                 found_ff;
   logic [POS_W-1:0]     found_key_ff;
   logic                 rsp_valid_ff;
   logic [OUT_FIELD_BITS-1:0] rsp_key_ff;
   logic                 rsp_report_ff;
   logic                 rsp_learned_ff;
   logic                 rsp_dup_ff;
   logic [OUT_FIELD_BITS-1:0] rsp_slot_ff;
   logic                 rsp_done_ff;

   logic [CODE_BITS-1:0] rd_data;
   logic                 hit;
   logic                 changed;
   logic [POS_W-1:0]     key_in;
   logic [POS_W-1:0]     pos_in;
   logic [POS_W-1:0]     pos_inc;
   logic [POS_W-1:0]     pos_dec;
   logic                 report_in;
   logic                 stored_in;
   logic                 dup_in;
   logic                 done_in;
   logic                 clear_table;
   logic [POS_W+3:0]     key_wide;
   logic [POS_W+3:0]     pos_wide;

   lircm_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (NUM_SLOTS),
      .ADDR_BITS (SLOT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.commit && stored_in),
      .wr_addr (pos_dec[SLOT_W-1:0]),
      .wr_data (code_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign hit = cmp_pend_ff && valid_ff[cmp_addr_ff] && (rd_data == code_ff);

   assign status.need_scan = !req_mode && (req_code != prev_ff) && (req_code != '0);
   assign status.scan_end  = cmp_pend_ff && (hit || (cmp_addr_ff == LAST_SLOT));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign changed = !mode_ff && (code_ff != prev_ff);
   assign pos_inc = pos_ff + POS_W'(1);
   assign pos_dec = pos_ff - POS_W'(1);

   always_comb begin
      key_in      = key_ff;
      pos_in      = pos_ff;
      report_in   = 1'b0;
      stored_in   = 1'b0;
      dup_in      = 1'b0;
      done_in     = 1'b0;
      clear_table = 1'b0;
      if (mode_ff) begin
         if (pos_ff == '0) begin
            clear_table = 1'b1;
            pos_in      = POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end else if (changed) begin
         key_in = found_ff ? found_key_ff : '0;
         if (pos_ff != '0) begin
            if (code_ff != '0) begin
               if (!found_ff) begin
                  stored_in = 1'b1;
                  if (pos_ff == MAX_POS) begin
                     pos_in  = '0;
                     done_in = 1'b1;
                  end else begin
                     pos_in = pos_inc;
                  end
               end else begin
                  dup_in = 1'b1;
               end
            end
         end else begin
            report_in = 1'b1;
         end
      end
   end

   assign key_wide = (POS_W + 4)'(key_in);
   assign pos_wide = (POS_W + 4)'(pos_in);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         code_ff <= req_code;
      end
      if (cmd.load) begin
         rd_addr_ff <= '0;
      end else if (cmd.scan && (rd_addr_ff != LAST_SLOT)) begin
         rd_addr_ff <= rd_addr_ff + SLOT_W'(1);
      end
      cmp_addr_ff <= rd_addr_ff;
      if (hit) begin
         found_key_ff <= POS_W'(cmp_addr_ff) + POS_W'(1);
      end
      if (cmd.commit) begin
         rsp_key_ff     <= key_wide[3:0];
         rsp_report_ff  <= report_in;
         rsp_learned_ff <= stored_in;
         rsp_dup_ff     <= dup_in;
         rsp_slot_ff    <= pos_wide[3:0];
         rsp_done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         key_ff       <= '0;
         pos_ff       <= '0;
         valid_ff     <= '0;
         cmp_pend_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.scan && !status.scan_end;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            if (changed) begin
               prev_ff <= code_ff;
            end
            key_ff <= key_in;
            pos_ff <= pos_in;
            if (clear_table) begin
               valid_ff <= '0;
            end else if (stored_in) begin
               valid_ff[pos_dec[SLOT_W-1:0]] <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_index     = rsp_key_ff;
   assign rsp_report_needed = rsp_report_ff;
   assign rsp_learned       = rsp_learned_ff;
   assign rsp_duplicate     = rsp_dup_ff;
   assign rsp_learn_slot    = rsp_slot_ff;
   assign rsp_learn_done    = rsp_done_ff;

endmodule

// ===== rtl/core/learned_ir_code_matcher_unit.sv =====
// Top level of the learned IR code matcher: controller plus datapath.
// Depends on lircm_pkg, lircm_ctrl, lircm_datapath (and lircm_ram below it).
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | mode, code
//   rsp_    | out       | rsp_valid/rsp_stall  | key_index, report_needed, learned,
//           |           |                      | duplicate, learn_slot, learn_done
//
// A button press, an unchanged code or a zero code skips the table scan and goes from accept
// straight to the finish state, where its result is registered once the output is free; a changed
// nonzero code first walks the table RAM slot by slot through its registered read port, and
// a match ends the walk early.
// Reset is synchronous; the table's valid bits clear at once, with no sweep.
// A stalled result holds in the output register; the next transaction is taken
// after the previous result has been loaded there.
module learned_ir_code_matcher_unit
   import lircm_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  logic [CODE_BITS-1:0]      req_code,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_FIELD_BITS-1:0] rsp_key_index,
   output logic                      rsp_report_needed,
   output logic                      rsp_learned,
   output logic                      rsp_duplicate,
   output logic [OUT_FIELD_BITS-1:0] rsp_learn_slot,
   output logic                      rsp_learn_done
);

   cmd_type    cmd;
   status_type status;

   lircm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lircm_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .CODE_BITS (CODE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_code          (req_code),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_key_index     (rsp_key_index),
      .rsp_report_needed (rsp_report_needed),
      .rsp_learned       (rsp_learned),
      .rsp_duplicate     (rsp_duplicate),
      .rsp_learn_slot    (rsp_learn_slot),
      .rsp_learn_done    (rsp_learn_done),
      .cmd               (cmd),
      .status            (status)
   );

endmodule
